### design/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg: shared definitions for the indexed deque store
// Opcodes, status codes and default sizes.
// ----------------------------------------------------------------------------
package ids_pkg;

	localparam int DEPTH_DEFAULT      = 64;
	localparam int VALUE_BITS_DEFAULT = 32;

	localparam int OP_BITS     = 3;
	localparam int POS_BITS    = 6;
	localparam int ENTRY_BITS  = 32;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 7;

	typedef logic [OP_BITS-1:0]     opcode_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam opcode_t OP_PUSH_FRONT = 3'd0;
	localparam opcode_t OP_PUSH_BACK  = 3'd1;
	localparam opcode_t OP_READ       = 3'd2;
	localparam opcode_t OP_POP_FRONT  = 3'd3;
	localparam opcode_t OP_POP_BACK   = 3'd4;
	localparam opcode_t OP_REMOVE_AT  = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

endpackage

### design/ids_ram.sv
// ----------------------------------------------------------------------------
// ids_ram: generic simple dual-port RAM
// One write port, one read port, read data registered. No reset on contents.
// ----------------------------------------------------------------------------
module ids_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/indexed_deque_store.sv
// ----------------------------------------------------------------------------
// indexed_deque_store: circular deque with read and remove at a position
// Push/pop at both ends, read at a logical position, remove-at that closes
// the gap by moving every later entry one slot toward the front.
// ----------------------------------------------------------------------------
// Usage:
//   An item (opcode, position, entry_value) is taken at a rising edge with
//   start high and busy low. busy then stays high until the result is out.
//   The result (value_out, status, count) is shown for exactly one cycle with
//   done high; the receiver cannot hold it off.
// Sequence, accept to result:
//   push front / push back / unused opcode / refused item : execute, done
//   read, pop front, pop back                              : execute, wait, done
//   remove at position                                     : execute, wait, shift, done
//   busy falls in the cycle after done rises. The remove-at time is set by the
//   single RAM port pair: one entry is read and one written per cycle while the
//   gap is closed.
// Reset:
//   arst_n clears head, length and the sequencer; the deque is empty. Entry
//   storage is not cleared, only live entries are ever read.
// ----------------------------------------------------------------------------
module indexed_deque_store #(
	parameter int DEPTH      = ids_pkg::DEPTH_DEFAULT,
	parameter int VALUE_BITS = ids_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ids_pkg::OP_BITS-1:0]     opcode,
	input  logic [ids_pkg::POS_BITS-1:0]    position,
	input  logic [ids_pkg::ENTRY_BITS-1:0]  entry_value,
	output logic                            done,
	output logic [ids_pkg::ENTRY_BITS-1:0]  value_out,
	output logic [ids_pkg::STATUS_BITS-1:0] status,
	output logic [ids_pkg::COUNT_BITS-1:0]  count
);

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > ids_pkg::POS_BITS) ? CW : ids_pkg::POS_BITS;

	localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);
	localparam logic [SW:0]   DEPTH_SUM  = (SW + 1)'(DEPTH);
	localparam logic [SW-1:0] LAST_SLOT  = SW'(DEPTH - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]              state_q;
	ids_pkg::opcode_t        op_q;
	logic [ids_pkg::POS_BITS-1:0] pos_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [SW-1:0]           head_q;
	logic [CW-1:0]           cnt_q;
	logic [VALUE_BITS-1:0]   res_q;
	ids_pkg::status_t        st_q;
	logic [SW-1:0]           rd_slot_q;
	logic [SW-1:0]           wr_slot_q;
	logic [CW-1:0]           moves_q;
	logic                    pend_q;

	logic                    full;
	logic                    empty;
	logic                    pos_bad;
	logic [SW:0]             offset;
	logic [SW:0]             slot_sum;
	logic [SW-1:0]           slot_off;
	logic [SW-1:0]           head_inc;
	logic [SW-1:0]           head_dec;
	logic [SW-1:0]           slot_off_inc;

	logic                    ram_we;
	logic [SW-1:0]           ram_waddr;
	logic [VALUE_BITS-1:0]   ram_wdata;
	logic [SW-1:0]           ram_raddr;
	logic [VALUE_BITS-1:0]   ram_rdata;

	assign full    = (cnt_q == DEPTH_CNT);
	assign empty   = (cnt_q == '0);
	assign pos_bad = (XW'(pos_q) >= XW'(cnt_q));

	// one shared slot adder: offset from head, wrapped modulo DEPTH
	always_comb begin
		unique case (op_q)
			ids_pkg::OP_PUSH_BACK: offset = (SW + 1)'(cnt_q);
			ids_pkg::OP_POP_BACK:  offset = (SW + 1)'(cnt_q - CW'(1));
			ids_pkg::OP_POP_FRONT: offset = '0;
			default:               offset = (SW + 1)'(pos_q);
		endcase
	end

	assign slot_sum     = {1'b0, head_q} + offset;
	assign slot_off     = (slot_sum >= DEPTH_SUM) ? SW'(slot_sum - DEPTH_SUM) : SW'(slot_sum);
	assign head_inc     = (head_q == LAST_SLOT) ? '0 : head_q + SW'(1);
	assign head_dec     = (head_q == '0) ? LAST_SLOT : head_q - SW'(1);
	assign slot_off_inc = (slot_off == LAST_SLOT) ? '0 : slot_off + SW'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_off;
		ram_wdata = val_q;
		ram_raddr = slot_off;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == ids_pkg::OP_PUSH_FRONT && !full) begin
					ram_we    = 1'b1;
					ram_waddr = head_dec;
				end else if (op_q == ids_pkg::OP_PUSH_BACK && !full) begin
					ram_we    = 1'b1;
				end
			end
			S_SHIFT: begin
				ram_raddr = rd_slot_q;
				ram_we    = pend_q;
				ram_waddr = wr_slot_q;
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	ids_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			moves_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						ids_pkg::OP_PUSH_FRONT: begin
							state_q <= S_DONE;
							if (!full) begin
								head_q <= head_dec;
								cnt_q  <= cnt_q + CW'(1);
							end
						end
						ids_pkg::OP_PUSH_BACK: begin
							state_q <= S_DONE;
							if (!full) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end
						ids_pkg::OP_READ: begin
							state_q <= pos_bad ? S_DONE : S_WAIT;
						end
						ids_pkg::OP_POP_FRONT: begin
							if (!empty) begin
								head_q  <= head_inc;
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_WAIT;
							end else begin
								state_q <= S_DONE;
							end
						end
						ids_pkg::OP_POP_BACK: begin
							if (!empty) begin
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_WAIT;
							end else begin
								state_q <= S_DONE;
							end
						end
						ids_pkg::OP_REMOVE_AT: begin
							if (!pos_bad) begin
								cnt_q   <= cnt_q - CW'(1);
								moves_q <= cnt_q - CW'(1) - CW'(pos_q);
								pend_q  <= 1'b0;
								state_q <= S_WAIT;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_WAIT: begin
					state_q <= (op_q == ids_pkg::OP_REMOVE_AT) ? S_SHIFT : S_DONE;
				end
				S_SHIFT: begin
					// read slot i+1 while slot i takes the previous read
					pend_q <= (moves_q != '0);
					if (moves_q != '0) begin
						moves_q <= moves_q - CW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload, result, status and slot registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= opcode;
			pos_q <= position;
			val_q <= VALUE_BITS'(entry_value);
		end
		if (state_q == S_EXEC) begin
			res_q     <= '0;
			wr_slot_q <= slot_off;
			rd_slot_q <= slot_off_inc;
			if ((op_q == ids_pkg::OP_PUSH_FRONT || op_q == ids_pkg::OP_PUSH_BACK) && full) begin
				st_q <= ids_pkg::ST_FULL;
			end else if ((op_q == ids_pkg::OP_READ || op_q == ids_pkg::OP_REMOVE_AT) && pos_bad) begin
				st_q <= ids_pkg::ST_EMPTY;
			end else if ((op_q == ids_pkg::OP_POP_FRONT || op_q == ids_pkg::OP_POP_BACK) && empty) begin
				st_q <= ids_pkg::ST_EMPTY;
			end else begin
				st_q <= ids_pkg::ST_OK;
			end
		end
		if (state_q == S_WAIT) begin
			res_q <= ram_rdata;
		end
		if (state_q == S_SHIFT) begin
			if (moves_q != '0) begin
				rd_slot_q <= (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + SW'(1);
			end
			if (pend_q) begin
				wr_slot_q <= (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + SW'(1);
			end
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);
	assign value_out = ids_pkg::ENTRY_BITS'(res_q);
	assign status    = st_q;
	assign count     = ids_pkg::COUNT_BITS'(cnt_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_CNT)
		else $error("entry count above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ids_pkg::ST_FULL) |-> full)
		else $error("full status while store not full");

endmodule
